// ----- sv/fmrq_pkg.sv -----
package fmrq_pkg;

	// Input item kinds.
	typedef enum logic [1:0] {
		KIND_LINE  = 2'd0,
		KIND_LOCAL = 2'd1,
		KIND_TICK  = 2'd2,
		KIND_POLL  = 2'd3
	} kind_t;

	// Enqueue status codes.
	localparam logic [1:0] STAT_QUEUED    = 2'd0;
	localparam logic [1:0] STAT_OVERWROTE = 2'd1;
	localparam logic [1:0] STAT_DROPPED   = 2'd2;

	// Result word kinds.
	localparam logic RES_STATUS = 1'b0;
	localparam logic RES_BYTE   = 1'b1;

	// Configuration register indexes and port widths.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 1'd1;

	// Register reset values and the fill byte of short messages.
	localparam logic [7:0]  START_BYTE_RST    = 8'hFE;
	localparam logic [15:0] POLL_INTERVAL_RST = 16'd5;
	localparam logic [7:0]  FILL_ZERO         = 8'h00;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_STATUS,
		S_COPY,
		S_DRAIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic load_status;
		logic copy_run;
		logic drain_run;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic enq_now;
		logic drain_now;
		logic copy_needed;
		logic copy_done;
		logic drain_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- sv/fmrq_ram.sv -----
module fmrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/fmrq_ctrl.sv -----
module fmrq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  fmrq_pkg::dp_stat_t   stat,
	output logic                 in_stall,
	output fmrq_pkg::ctrl_cmd_t  cmd
);
	import fmrq_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
				if (in_valid) begin
					if (stat.enq_now) begin
						state_d = S_STATUS;
					end else if (stat.drain_now) begin
						state_d = S_DRAIN;
					end
				end
			end
			S_STATUS: begin
				cmd.load_status = stat.out_free;
				if (stat.out_free) begin
					state_d = stat.copy_needed ? S_COPY : S_IDLE;
				end
			end
			S_COPY: begin
				cmd.copy_run = 1'b1;
				if (stat.copy_done) begin
					state_d = S_IDLE;
				end
			end
			S_DRAIN: begin
				cmd.drain_run = 1'b1;
				if (stat.drain_done) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

endmodule

// ----- sv/fmrq_dp.sv -----
module fmrq_dp #(
	parameter int QUEUE_DEPTH = 8,
	parameter int MSG_BYTES   = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fmrq_pkg::ctrl_cmd_t               cmd,
	output fmrq_pkg::dp_stat_t                stat,
	input  logic                              cfg_we,
	input  logic [fmrq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fmrq_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [1:0]                        kind,
	input  logic [7:0]                        data,
	input  logic                              last,
	input  logic                              mandatory,
	input  logic                              sink_ready,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic                              result_kind,
	output logic [1:0]                        status,
	output logic [7:0]                        byte_out,
	output logic                              end_of_run,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]  fill_count
);
	import fmrq_pkg::*;

	localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int MA_W        = $clog2(MSG_BYTES);
	localparam int IDX_W       = $clog2(MSG_BYTES + 1);
	localparam int STORE_DEPTH = QUEUE_DEPTH * MSG_BYTES;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT   = CNT_W'(QUEUE_DEPTH);
	localparam logic [IDX_W-1:0]  MSG_CNT    = IDX_W'(MSG_BYTES);
	localparam logic [IDX_W-1:0]  MSG_LAST   = IDX_W'(MSG_BYTES - 1);
	localparam logic [MA_W-1:0]   POS_LAST   = MA_W'(MSG_BYTES - 1);
	localparam logic [ADDR_W-1:0] MSG_STRIDE = ADDR_W'(MSG_BYTES);

	// Configuration registers.
	logic [7:0]  start_byte_q;
	logic [15:0] poll_interval_q;

	// Queue, framing and time state.
	logic [SLOT_W-1:0] head_q;
	logic [SLOT_W-1:0] tail_q;
	logic [CNT_W-1:0]  held_q;
	logic              rx_on_q;
	logic [MA_W-1:0]   rx_pos_q;
	logic [IDX_W-1:0]  local_len_q;
	logic [31:0]       time_now_q;
	logic [31:0]       last_drain_q;

	// Job registers set when an item finishes a message or starts a drain.
	logic [1:0]        job_stat_q;
	logic              job_copy_q;
	logic              job_local_q;
	logic [IDX_W-1:0]  job_len_q;
	logic [ADDR_W-1:0] base_q;

	// Sweep counter and pipeline.
	logic [IDX_W-1:0]  idx_q;
	logic              cp_valid_s1;
	logic [MA_W-1:0]   cp_idx_s1;
	logic              pend_q;
	logic              pend_last_q;

	// Memory ports.
	logic              frm_we;
	logic [MA_W-1:0]   frm_waddr;
	logic [7:0]        frm_rdata;
	logic              loc_we;
	logic [MA_W-1:0]   loc_waddr;
	logic [7:0]        loc_rdata;
	logic              stg_re;
	logic              st_we;
	logic [ADDR_W-1:0] st_waddr;
	logic [7:0]        st_wdata;
	logic              st_re;
	logic [ADDR_W-1:0] st_raddr;
	logic [7:0]        st_rdata;

	// Decode.
	logic              is_line;
	logic              is_local;
	logic              is_tick;
	logic              is_poll;
	logic              start_hit;
	logic              line_final;
	logic              loc_room;
	logic              loc_final;
	logic              enq_now;
	logic              poll_ok;
	logic              has_room;
	logic [31:0]       elapsed;
	logic [IDX_W-1:0]  enq_len;
	logic [1:0]        enq_code;
	logic [SLOT_W-1:0] enq_slot;
	logic [SLOT_W-1:0] tail_next;
	logic [SLOT_W-1:0] head_next;
	logic              dr_issue;
	logic              dr_load;
	logic              out_free;
	logic              out_load;

	// Item decode and the enqueue and drain decisions.
	always_comb begin
		is_line    = (kind == KIND_LINE);
		is_local   = (kind == KIND_LOCAL);
		is_tick    = (kind == KIND_TICK);
		is_poll    = (kind == KIND_POLL);
		start_hit  = (data == start_byte_q);
		line_final = is_line && rx_on_q && (rx_pos_q == POS_LAST);
		loc_room   = (local_len_q < MSG_CNT);
		loc_final  = is_local && last;
		enq_now    = line_final || loc_final;
		elapsed    = time_now_q - last_drain_q;
		poll_ok    = is_poll && (held_q != '0) && sink_ready &&
			(elapsed > {16'd0, poll_interval_q});
		has_room   = (held_q < FULL_CNT);
		if (is_line || !loc_room) begin
			enq_len = MSG_CNT;
		end else begin
			enq_len = local_len_q + 1'b1;
		end
		if (has_room) begin
			enq_code = STAT_QUEUED;
		end else if (is_local && mandatory) begin
			enq_code = STAT_OVERWROTE;
		end else begin
			enq_code = STAT_DROPPED;
		end
		enq_slot  = has_room ? tail_q : LAST_SLOT;
		tail_next = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
		head_next = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
	end

	// Staging writes on accepted bytes, reads during the copy sweep.
	assign frm_we    = cmd.take && is_line && (rx_on_q || start_hit);
	assign frm_waddr = rx_on_q ? rx_pos_q : '0;
	assign loc_we    = cmd.take && is_local && loc_room;
	assign loc_waddr = local_len_q[MA_W-1:0];
	assign stg_re    = cmd.copy_run && (idx_q < MSG_CNT);

	// Slot store: the copy sweep writes, the drain sweep reads.
	assign st_we    = cp_valid_s1;
	assign st_waddr = base_q + ADDR_W'(cp_idx_s1);
	assign st_wdata = (IDX_W'(cp_idx_s1) < job_len_q) ?
		(job_local_q ? loc_rdata : frm_rdata) : FILL_ZERO;

	// A new drain read goes out when the previous byte has left the read register.
	assign out_free = !out_valid || !out_stall;
	assign dr_load  = cmd.drain_run && pend_q && out_free;
	assign dr_issue = cmd.drain_run && (idx_q < MSG_CNT) && (!pend_q || dr_load);
	assign st_re    = dr_issue;
	assign st_raddr = base_q + ADDR_W'(idx_q[MA_W-1:0]);
	assign out_load = cmd.load_status || dr_load;

	// Status to the controller.
	always_comb begin
		stat             = '0;
		stat.enq_now     = enq_now;
		stat.drain_now   = poll_ok;
		stat.copy_needed = job_copy_q;
		stat.copy_done   = (idx_q == MSG_CNT) && !cp_valid_s1;
		stat.drain_done  = (idx_q == MSG_CNT) && !pend_q;
		stat.out_free    = out_free;
	end

	// Configuration, queue, framing and time registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q    <= START_BYTE_RST;
			poll_interval_q <= POLL_INTERVAL_RST;
			head_q          <= '0;
			tail_q          <= '0;
			held_q          <= '0;
			rx_on_q         <= 1'b0;
			rx_pos_q        <= '0;
			local_len_q     <= '0;
			time_now_q      <= '0;
			last_drain_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_START_BYTE:    start_byte_q    <= cfg_data[7:0];
					CFG_POLL_INTERVAL: poll_interval_q <= cfg_data;
				endcase
			end
			if (cmd.take) begin
				if (is_line) begin
					if (!rx_on_q) begin
						if (start_hit) begin
							rx_on_q  <= 1'b1;
							rx_pos_q <= MA_W'(1);
						end
					end else if (line_final) begin
						rx_on_q  <= 1'b0;
						rx_pos_q <= '0;
					end else begin
						rx_pos_q <= rx_pos_q + 1'b1;
					end
				end
				if (is_local) begin
					if (last) begin
						local_len_q <= '0;
					end else if (loc_room) begin
						local_len_q <= local_len_q + 1'b1;
					end
				end
				if (is_tick) begin
					time_now_q <= time_now_q + 32'd1;
				end
				if (poll_ok) begin
					head_q       <= head_next;
					held_q       <= held_q - 1'b1;
					last_drain_q <= time_now_q;
				end
				if (enq_now && has_room) begin
					tail_q <= tail_next;
					held_q <= held_q + 1'b1;
				end
			end
		end
	end

	// Job setup for the copy or drain that follows the item.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			if (enq_now) begin
				job_stat_q  <= enq_code;
				job_copy_q  <= (enq_code != STAT_DROPPED);
				job_local_q <= is_local;
				job_len_q   <= enq_len;
				base_q      <= ADDR_W'(enq_slot) * MSG_STRIDE;
			end else if (poll_ok) begin
				base_q <= ADDR_W'(head_q) * MSG_STRIDE;
			end
		end
	end

	// Sweep counter, copy write stage and drain read tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cp_valid_s1 <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			cp_valid_s1 <= stg_re;
			if (cmd.take) begin
				idx_q  <= '0;
				pend_q <= 1'b0;
			end else begin
				if (stg_re || dr_issue) begin
					idx_q <= idx_q + 1'b1;
				end
				if (dr_issue) begin
					pend_q <= 1'b1;
				end else if (dr_load) begin
					pend_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stg_re) begin
			cp_idx_s1 <= idx_q[MA_W-1:0];
		end
		if (dr_issue) begin
			pend_last_q <= (idx_q == MSG_LAST);
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_free) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			fill_count <= held_q;
			if (cmd.load_status) begin
				result_kind <= RES_STATUS;
				status      <= job_stat_q;
				byte_out    <= FILL_ZERO;
				end_of_run  <= 1'b1;
			end else begin
				result_kind <= RES_BYTE;
				status      <= STAT_QUEUED;
				byte_out    <= st_rdata;
				end_of_run  <= pend_last_q;
			end
		end
	end

	// Line frame staging.
	fmrq_ram #(
		.WIDTH (8),
		.DEPTH (MSG_BYTES)
	) u_frm_ram (
		.clk   (clk),
		.we    (frm_we),
		.waddr (frm_waddr),
		.wdata (data),
		.re    (stg_re),
		.raddr (idx_q[MA_W-1:0]),
		.rdata (frm_rdata)
	);

	// Local message staging.
	fmrq_ram #(
		.WIDTH (8),
		.DEPTH (MSG_BYTES)
	) u_loc_ram (
		.clk   (clk),
		.we    (loc_we),
		.waddr (loc_waddr),
		.wdata (data),
		.re    (stg_re),
		.raddr (idx_q[MA_W-1:0]),
		.rdata (loc_rdata)
	);

	// Slot store.
	fmrq_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

endmodule

// ----- sv/framed_message_ring_queue.sv -----
// Line bytes and local bytes that do not end a message, ticks and unserved polls leave the block idle.
// A finished message gives its status word through the output register once it is free, then,
// unless dropped, copies the staging buffer into its slot through the slot RAM write port.
// A served poll gives MSG_BYTES words, one per cycle while out_stall allows, each read into
// the slot RAM read register and then loaded into the output register.
// Reset clears control, pointers, counts and time; start byte is 0xFE, poll interval 5.
module framed_message_ring_queue #(
	parameter int QUEUE_DEPTH = 8,
	parameter int MSG_BYTES   = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fmrq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fmrq_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        kind,
	input  logic [7:0]                        data,
	input  logic                              last,
	input  logic                              mandatory,
	input  logic                              sink_ready,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              result_kind,
	output logic [1:0]                        status,
	output logic [7:0]                        byte_out,
	output logic                              end_of_run,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]  fill_count
);
	import fmrq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	fmrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	fmrq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MSG_BYTES   (MSG_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.kind        (kind),
		.data        (data),
		.last        (last),
		.mandatory   (mandatory),
		.sink_ready  (sink_ready),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.result_kind (result_kind),
		.status      (status),
		.byte_out    (byte_out),
		.end_of_run  (end_of_run),
		.fill_count  (fill_count)
	);

`ifndef SYNTH
	// Only one kind of work runs in any cycle.
	a_one_job: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.load_status, cmd.copy_run, cmd.drain_run}))
		else $error("more than one job active");

	// No item is taken while a copy or drain sweep is running.
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.copy_run || cmd.drain_run) |-> in_stall)
		else $error("input open during a sweep");

	// A finished copy returns the block to taking items.
	a_copy_release: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.copy_run && stat.copy_done) |=> !in_stall)
		else $error("block stuck after copy");

	// The reported fill never exceeds the queue depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fill_count <= CNT_W'(QUEUE_DEPTH)))
		else $error("fill count beyond depth");
`endif

endmodule

// ----- bench/framed_message_ring_queue_tb.sv -----
`timescale 1ns / 100ps

module framed_message_ring_queue_tb;
	import fmrq_pkg::*;

	localparam int QUEUE_DEPTH = 8;
	localparam int MSG_BYTES   = 12;
	localparam int CLK_PERIOD  = 8;
	localparam int STALL_LIMIT = 2000;
	// Cycles the block may still spend copying a slot after its status word.
	localparam int SETTLE_CYCLES = MSG_BYTES + 8;

	// One result word as the block presents it.
	typedef struct packed {
		logic       res_kind;
		logic [1:0] stat;
		logic [7:0] value;
		logic       run_end;
		logic [3:0] fill;
	} word_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                cfg_we;
	logic [CFG_IDX_W-1:0]                cfg_index;
	logic [CFG_DATA_W-1:0]               cfg_data;
	logic                                in_valid;
	logic                                in_stall;
	logic [1:0]                          kind;
	logic [7:0]                          data;
	logic                                last;
	logic                                mandatory;
	logic                                sink_ready;
	logic                                out_valid;
	logic                                out_stall;
	logic                                result_kind;
	logic [1:0]                          status;
	logic [7:0]                          byte_out;
	logic                                end_of_run;
	logic [$clog2(QUEUE_DEPTH+1)-1:0]    fill_count;

	// Predicted queue state and register copies.
	logic [MSG_BYTES*8-1:0] slot_img [QUEUE_DEPTH];
	int                     head_idx;
	int                     tail_idx;
	int                     held;
	bit                     frame_busy;
	int                     frame_pos;
	logic [MSG_BYTES*8-1:0] frame_buf;
	logic [MSG_BYTES*8-1:0] local_buf;
	int                     local_len;
	logic [31:0]            ticks_now;
	logic [31:0]            last_drain;
	logic [7:0]             frame_start;
	logic [15:0]            poll_gap;

	word_t awaited_words [$];
	int    mismatches   = 0;
	int    useful_words = 0;
	bit    calm         = 1'b0;

	framed_message_ring_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.MSG_BYTES(MSG_BYTES)
	) dut (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic coin();
		return $urandom_range(1) == 1;
	endfunction

	// Put a finished message into the ring and post its status word.
	task automatic store_message(input logic [MSG_BYTES*8-1:0] msg, input int len,
			input logic must);
		logic [1:0] st;
		int         i;
		// Slot bytes past the message length are zero.
		for (i = len; i < MSG_BYTES; i++) msg[i*8 +: 8] = 8'h00;
		if (held < QUEUE_DEPTH) begin
			slot_img[tail_idx] = msg;
			tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
			held++;
			st = STAT_QUEUED;
		end else if (must) begin
			slot_img[QUEUE_DEPTH-1] = msg;
			st = STAT_OVERWROTE;
		end else begin
			st = STAT_DROPPED;
		end
		awaited_words.push_back('{RES_STATUS, st, 8'h00, 1'b1, 4'(held)});
	endtask

	// Advance the predicted queue by one accepted word.
	task automatic apply_to_queue(input kind_t k, input logic [7:0] d, input logic lst,
			input logic must, input logic rdy, output bit ignored);
		logic [31:0] elapsed;
		int          i;
		ignored = 1'b0;
		case (k)
			KIND_LINE: begin
				if (!frame_busy) begin
					// Hunt for the start byte; anything else is thrown away.
					if (d == frame_start) begin
						frame_buf[7:0] = d;
						frame_pos = 1;
						frame_busy = 1'b1;
					end else begin
						ignored = 1'b1;
					end
				end else begin
					frame_buf[frame_pos*8 +: 8] = d;
					frame_pos++;
					if (frame_pos == MSG_BYTES) begin
						frame_busy = 1'b0;
						frame_pos = 0;
						store_message(frame_buf, MSG_BYTES, 1'b0);
					end
				end
			end
			KIND_LOCAL: begin
				// Bytes past the slot length are dropped, the last mark still counts.
				if (local_len < MSG_BYTES) begin
					local_buf[local_len*8 +: 8] = d;
					local_len++;
				end else if (!lst) begin
					ignored = 1'b1;
				end
				if (lst) begin
					store_message(local_buf, local_len, must);
					local_len = 0;
				end
			end
			KIND_TICK: ticks_now++;
			KIND_POLL: begin
				elapsed = ticks_now - last_drain;
				if (held == 0 || !rdy || elapsed <= {16'd0, poll_gap}) begin
					ignored = 1'b1;
				end else begin
					held--;
					last_drain = ticks_now;
					// Status is fixed at zero in drained byte words.
					for (i = 0; i < MSG_BYTES; i++)
						awaited_words.push_back('{RES_BYTE, STAT_QUEUED,
							slot_img[head_idx][i*8 +: 8], i == MSG_BYTES - 1, 4'(held)});
					head_idx = (head_idx + 1) % QUEUE_DEPTH;
				end
			end
		endcase
	endtask

	// Offer one input word, with random idle cycles ahead of it unless calm is set, and wait for acceptance.
	task automatic send_word(input kind_t k, input logic [7:0] d, input logic lst,
			input logic must, input logic rdy);
		bit taken;
		bit ignored;
		while (!calm && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		data       <= d;
		last       <= lst;
		mandatory  <= must;
		sink_ready <= rdy;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = (in_stall === 1'b0);
		end
		apply_to_queue(k, d, lst, must, rdy, ignored);
		if (!ignored) useful_words++;
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_word(KIND_TICK, 8'($urandom), coin(), coin(), coin());
	endtask

	// Tick until the poll interval has passed, then poll with the sink ready.
	task automatic drain_one();
		while (ticks_now - last_drain <= {16'd0, poll_gap}) send_tick();
		send_word(KIND_POLL, 8'($urandom), coin(), coin(), 1'b1);
	endtask

	// A whole line frame opened by the current start byte.
	task automatic send_line_frame();
		int i;
		send_word(KIND_LINE, frame_start, coin(), coin(), coin());
		for (i = 1; i < MSG_BYTES; i++)
			send_word(KIND_LINE, 8'($urandom), coin(), coin(), coin());
	endtask

	// Stop sending and wait until every predicted word is out and the block is idle.
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (awaited_words.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == CFG_START_BYTE)
			frame_start = value[7:0];
		else
			poll_gap = value;
	endtask

	task automatic test_line_framing();
		int i;
		logic [7:0] d;
		// Noise ahead of the start byte is skipped.
		send_word(KIND_LINE, 8'h00, 1'b0, 1'b0, 1'b0);
		send_word(KIND_LINE, 8'hFF, 1'b1, 1'b1, 1'b1);
		send_word(KIND_LINE, 8'hFD, 1'b0, 1'b1, 1'b0);
		send_word(KIND_LINE, frame_start, 1'b1, 1'b0, 1'b1);
		// Inside a frame the start byte value is plain data.
		for (i = 1; i < MSG_BYTES; i++) begin
			d = (i == 1) ? 8'h00 : (i == 2) ? 8'hFF : (i == 3) ? frame_start : 8'($urandom);
			send_word(KIND_LINE, d, coin(), coin(), coin());
		end
	endtask

	task automatic test_local_messages();
		int i;
		// A one-byte message is padded with zeros.
		send_word(KIND_LOCAL, 8'hFF, 1'b1, 1'b0, 1'b0);
		// A local message assembled while a line frame is under way.
		send_word(KIND_LINE, frame_start, 1'b0, 1'b0, 1'b0);
		for (i = 0; i < 3; i++) send_word(KIND_LINE, 8'($urandom), 1'b0, 1'b0, 1'b0);
		send_word(KIND_LOCAL, 8'hA5, 1'b0, 1'b0, 1'b1);
		send_word(KIND_LOCAL, 8'h00, 1'b1, 1'b0, 1'b1);
		for (i = 4; i < MSG_BYTES; i++) send_word(KIND_LINE, 8'($urandom), 1'b0, 1'b0, 1'b0);
		// An overlong message is cut to one slot.
		for (i = 0; i < MSG_BYTES + 2; i++)
			send_word(KIND_LOCAL, 8'(i + 1), i == MSG_BYTES + 1, 1'b1, coin());
	endtask

	task automatic test_drain_poll();
		while (ticks_now - last_drain <= {16'd0, poll_gap}) send_tick();
		// A poll with the sink busy is not served; the next one is, and one right after is not.
		send_word(KIND_POLL, 8'h00, 1'b0, 1'b0, 1'b0);
		send_word(KIND_POLL, 8'hFF, 1'b1, 1'b1, 1'b1);
		send_word(KIND_POLL, 8'h00, 1'b0, 1'b0, 1'b1);
		while (held > 0) drain_one();
	endtask

	task automatic test_full_queue();
		while (held < QUEUE_DEPTH) send_word(KIND_LOCAL, 8'($urandom), 1'b1, 1'b0, coin());
		// Mandatory message overwrites the last slot, others are dropped.
		send_word(KIND_LOCAL, 8'h11, 1'b0, 1'b0, 1'b0);
		send_word(KIND_LOCAL, 8'h22, 1'b1, 1'b1, 1'b0);
		send_word(KIND_LOCAL, 8'h33, 1'b1, 1'b0, 1'b1);
		send_line_frame();
		while (held > 0) drain_one();
		// A poll on an empty queue gives nothing.
		drain_one();
	endtask

	task automatic test_start_byte_extremes();
		hold_until_drained();
		write_register(CFG_START_BYTE, 16'h0000);
		send_word(KIND_LINE, 8'hFF, 1'b0, 1'b0, 1'b0);
		send_line_frame();
		hold_until_drained();
		write_register(CFG_START_BYTE, 16'h00FF);
		send_word(KIND_LINE, 8'h00, 1'b0, 1'b0, 1'b0);
		send_line_frame();
		while (held > 0) drain_one();
	endtask

	task automatic test_poll_interval_extremes();
		hold_until_drained();
		write_register(CFG_POLL_INTERVAL, 16'hFFFF);
		if (held == 0) send_word(KIND_LOCAL, 8'h5A, 1'b1, 1'b0, 1'b0);
		// With the largest interval, polls shortly after a drain are too early.
		send_word(KIND_POLL, 8'h00, 1'b0, 1'b0, 1'b1);
		send_tick();
		send_word(KIND_POLL, 8'hFF, 1'b1, 1'b1, 1'b1);
		hold_until_drained();
		write_register(CFG_POLL_INTERVAL, 16'd20);
		// Tick straight up to the interval: a poll there is still too early.
		calm = 1'b1;
		while (ticks_now - last_drain < 32'd20) send_tick();
		send_word(KIND_POLL, 8'h00, 1'b0, 1'b0, 1'b1);
		send_tick();
		send_word(KIND_POLL, 8'hFF, 1'b1, 1'b1, 1'b1);
		calm = 1'b0;
		hold_until_drained();
		// With a zero interval a single tick is enough.
		write_register(CFG_POLL_INTERVAL, 16'h0000);
		if (held == 0) send_word(KIND_LOCAL, 8'hC3, 1'b1, 1'b1, 1'b0);
		send_word(KIND_POLL, 8'h00, 1'b0, 1'b0, 1'b1);
		send_tick();
		send_word(KIND_POLL, 8'h00, 1'b0, 1'b0, 1'b1);
	endtask

	// Mixed traffic: well-formed frames and local messages with ticks, polls and noise.
	task automatic random_traffic(input int count, input int w_line, input int w_local,
			input int w_tick);
		int         target;
		int         pick;
		int         msg_left;
		logic [7:0] d;
		msg_left = 0;
		target = useful_words + count;
		while (useful_words < target) begin
			pick = $urandom_range(99);
			d = 8'($urandom);
			if (pick < w_line) begin
				if (!frame_busy && $urandom_range(99) < 80) d = frame_start;
				send_word(KIND_LINE, d, coin(), coin(), coin());
			end else if (pick < w_line + w_local) begin
				if (msg_left == 0)
					msg_left = ($urandom_range(9) == 0) ?
						$urandom_range(MSG_BYTES + 4, MSG_BYTES + 1) : $urandom_range(MSG_BYTES, 1);
				msg_left--;
				send_word(KIND_LOCAL, d, msg_left == 0, coin(), coin());
			end else if (pick < w_line + w_local + w_tick) begin
				send_tick();
			end else begin
				send_word(KIND_POLL, d, coin(), coin(), $urandom_range(99) < 85);
			end
		end
	endtask

	task automatic test_random_traffic();
		hold_until_drained();
		write_register(CFG_START_BYTE, 16'(START_BYTE_RST));
		write_register(CFG_POLL_INTERVAL, POLL_INTERVAL_RST);
		random_traffic(45, 30, 25, 25);
		// The sender holds off here until every word has come out.
		hold_until_drained();
		write_register(CFG_START_BYTE, 16'($urandom_range(255)));
		write_register(CFG_POLL_INTERVAL, 16'h0000);
		calm = 1'b1;
		random_traffic(40, 20, 20, 20);
		calm = 1'b0;
		hold_until_drained();
		write_register(CFG_START_BYTE, 16'h0000);
		write_register(CFG_POLL_INTERVAL, 16'd2);
		random_traffic(35, 35, 40, 15);
	endtask

	// Receiver side: random stalls unless a calm stretch is running.
	always @(negedge clk) out_stall <= calm ? 1'b0 : ($urandom_range(99) < 32);

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Every accepted result word is checked against the oldest prediction.
	always @(posedge clk) begin : check_word
		word_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (awaited_words.size() == 0) begin
				$error("unexpected word: result_kind %0d status %0d byte_out %0d",
					result_kind, status, byte_out);
				mismatches++;
			end else begin
				want = awaited_words.pop_front();
				compare_field("result_kind", 16'(want.res_kind), 16'(result_kind));
				compare_field("status", 16'(want.stat), 16'(status));
				compare_field("byte_out", 16'(want.value), 16'(byte_out));
				compare_field("end_of_run", 16'(want.run_end), 16'(end_of_run));
				compare_field("fill_count", 16'(want.fill), 16'(fill_count));
			end
		end
	end

	// Watchdog: too many cycles without any word accepted on either side.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
					(out_valid === 1'b1 && out_stall === 1'b0))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= CFG_START_BYTE;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		kind       <= KIND_TICK;
		data       <= 8'h00;
		last       <= 1'b0;
		mandatory  <= 1'b0;
		sink_ready <= 1'b0;
		// Predicted state after reset.
		foreach (slot_img[i]) slot_img[i] = '0;
		head_idx    = 0;
		tail_idx    = 0;
		held        = 0;
		frame_busy  = 1'b0;
		frame_pos   = 0;
		frame_buf   = '0;
		local_buf   = '0;
		local_len   = 0;
		ticks_now   = '0;
		last_drain  = '0;
		frame_start = START_BYTE_RST;
		poll_gap    = POLL_INTERVAL_RST;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_line_framing();
		test_local_messages();
		test_drain_poll();
		test_full_queue();
		test_start_byte_extremes();
		test_poll_interval_extremes();
		test_random_traffic();
		hold_until_drained();

		if (mismatches == 0 && awaited_words.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
